// ===== hdl/nearest_palette_color_mapper_macros.svh =====
// assertion helpers for the palette mapper
// NPPM_ASSERT_SAME: cond holds in the same cycle as trig
// NPPM_ASSERT_NEXT: cond holds in the cycle after trig
`ifndef NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH

`ifndef SYNTH

`define NPPM_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("nppm check failed");

`define NPPM_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("nppm check failed");

`else

`define NPPM_ASSERT_SAME(lbl, clk, rst_n, trig, cond)

`define NPPM_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// ===== hdl/nppm_pkg.sv =====
`default_nettype none

package nppm_pkg;

    // channel and distance widths
    localparam int CH_W      = 8;
    localparam int SQ_W      = 2 * CH_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int SLOT_W    = 4;
    localparam int IDX_OUT_W = 4;
    localparam int SIZE_W    = 5;
    localparam int TDATA_W   = 32;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    // beat kinds carried on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_PALETTE_SIZE = 1'b0;

    typedef struct packed {
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } t_rgb;

endpackage

`default_nettype wire

// ===== hdl/nearest_palette_color_mapper.sv =====
// nearest palette color mapper
// input stream beats carry either a palette write (tuser 0: entry_slot and color)
// or a pixel to map (tuser 1: color). palette writes take effect at acceptance
// and later pixels see them; they give no output beat.
// each mapped pixel gives one output beat: the color and index of the palette
// entry nearest by squared RGB distance, lowest index on equal distance,
// black and index 0 when palette_size is 0.
// palette_size sits on the APB port at address 0; write it only while idle.
// pipeline from input beat to output beat: input register, squares, sum,
// one level per compare-tree level, output register.
// throughput: one beat per cycle while the output beat is taken; every palette
// entry has its own distance lane and the compare tree is fully pipelined.
// stall: the whole pipeline holds while the output beat is not taken, and
// s_tready drops with it; nothing is lost or repeated.
// reset clears valids and palette_size; palette entries are undefined until
// written and must be written before a pixel uses them.
`default_nettype none
`include "nearest_palette_color_mapper_macros.svh"

module nearest_palette_color_mapper #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [nppm_pkg::TDATA_W-1:0] i_s_tdata, // entry_slot, red_in, green_in, blue_in
    input  wire logic [0:0]  i_s_tuser,                  // func
    // stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [nppm_pkg::TDATA_W-1:0] o_m_tdata,      // red_out, green_out, blue_out, chosen_index
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [nppm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [nppm_pkg::APB_W-1:0]   pwdata,
    output logic [nppm_pkg::APB_W-1:0]        prdata,
    output logic             pready
);
    import nppm_pkg::*;

    localparam int IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LVLS    = $clog2(PALETTE_DEPTH);
    localparam int VLD_N   = 2 + LVLS;
    localparam int CNT_W   = ($clog2(PALETTE_DEPTH + 1) > SIZE_W) ?
                             $clog2(PALETTE_DEPTH + 1) : SIZE_W;
    localparam int SCMP_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    logic             w_en, w_acc;
    logic [SLOT_W-1:0] w_slot;
    t_rgb             w_in_rgb;
    logic [SIZE_W-1:0] r_palette_size;
    logic [CNT_W-1:0] w_count;
    t_rgb             r_palette [PALETTE_DEPTH];
    logic             r_s1_vld;
    t_rgb             r_s1_rgb;
    logic [VLD_N-1:0] r_vld_sh;
    logic             r_out_vld;
    t_rgb             r_out_rgb;
    logic [IDX_W-1:0] r_out_idx;
    logic [IDX_W+IDX_OUT_W-1:0] w_idx_ext;

    logic [DIST_W-1:0] w_dist [PALETTE_DEPTH];
    t_rgb             w_ent  [PALETTE_DEPTH];
    logic             w_act  [PALETTE_DEPTH];
    logic             w_found;
    logic [IDX_W-1:0] w_best_idx;
    t_rgb             w_best_rgb;

    // config register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_PALETTE_SIZE)) begin
            r_palette_size <= pwdata[SIZE_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_PALETTE_SIZE) ? APB_W'(r_palette_size) : '0;

    // entries in use, saturated at depth
    assign w_count = (CNT_W'(r_palette_size) > CNT_W'(PALETTE_DEPTH)) ?
                     CNT_W'(PALETTE_DEPTH) : CNT_W'(r_palette_size);

    // global pipeline advance
    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && o_s_tready;

    assign w_slot     = i_s_tdata[SLOT_W-1:0];
    assign w_in_rgb.r = i_s_tdata[SLOT_W +: CH_W];
    assign w_in_rgb.g = i_s_tdata[SLOT_W+CH_W +: CH_W];
    assign w_in_rgb.b = i_s_tdata[SLOT_W+2*CH_W +: CH_W];

    // palette store, written at acceptance so the pixel in stage 1 still
    // reads the entries that preceded it
    for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_pal
        always_ff @(posedge i_clk) begin
            if (w_acc && (i_s_tuser[0] == FUNC_WRITE)
                && (SCMP_W'(w_slot) == SCMP_W'(j))) begin
                r_palette[j] <= w_in_rgb;
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_tvalid && (i_s_tuser[0] == FUNC_MAP);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_rgb <= w_in_rgb;
        end
    end

    // distance lanes
    for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_lane
        nppm_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_pix  (r_s1_rgb),
            .i_ent  (r_palette[j]),
            .i_act  (CNT_W'(j) < w_count),
            .o_dist (w_dist[j]),
            .o_ent  (w_ent[j]),
            .o_act  (w_act[j])
        );
    end

    // compare tree
    nppm_min_tree #(
        .DEPTH (PALETTE_DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dist  (w_dist),
        .i_ent   (w_ent),
        .i_act   (w_act),
        .o_found (w_found),
        .o_idx   (w_best_idx),
        .o_rgb   (w_best_rgb)
    );

    // valid bits alongside lanes and tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sh  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld_sh  <= {r_vld_sh[VLD_N-2:0], r_s1_vld};
            r_out_vld <= r_vld_sh[VLD_N-1];
        end
    end

    // output register, black when no entry in use
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_rgb <= w_found ? w_best_rgb : '0;
            r_out_idx <= w_found ? w_best_idx : '0;
        end
    end

    assign w_idx_ext  = {{IDX_OUT_W{1'b0}}, r_out_idx};
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = TDATA_W'({w_idx_ext[IDX_OUT_W-1:0], r_out_rgb.b,
                                  r_out_rgb.g, r_out_rgb.r});

    // checks
    `NPPM_ASSERT_SAME(a_idx_in_use, i_clk, i_rst_n, o_m_tvalid, (CNT_W'(r_out_idx) < w_count) || (r_out_idx == '0))
    `NPPM_ASSERT_SAME(a_empty_black, i_clk, i_rst_n, o_m_tvalid && (w_count == '0), (r_out_rgb == '0) && (r_out_idx == '0))
    `NPPM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld_sh) && $stable(r_out_vld))

endmodule

`default_nettype wire

// ===== hdl/nppm_lane.sv =====
`default_nettype none

// one palette entry: squared channel differences, then their sum
module nppm_lane (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire nppm_pkg::t_rgb i_pix,
    input  wire nppm_pkg::t_rgb i_ent,
    input  wire logic         i_act,
    output logic [nppm_pkg::DIST_W-1:0] o_dist,
    output nppm_pkg::t_rgb    o_ent,
    output logic              o_act
);
    import nppm_pkg::*;

    logic [CH_W-1:0] w_dr, w_dg, w_db;
    logic [SQ_W-1:0] r_sq_r, r_sq_g, r_sq_b;
    t_rgb            r_ent2, r_ent3;
    logic            r_act2, r_act3;
    logic [DIST_W-1:0] r_dist;

    // absolute differences
    assign w_dr = (i_pix.r > i_ent.r) ? (i_pix.r - i_ent.r) : (i_ent.r - i_pix.r);
    assign w_dg = (i_pix.g > i_ent.g) ? (i_pix.g - i_ent.g) : (i_ent.g - i_pix.g);
    assign w_db = (i_pix.b > i_ent.b) ? (i_pix.b - i_ent.b) : (i_ent.b - i_pix.b);

    // stage 2: squares, entry snapshot
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_r <= SQ_W'(w_dr) * SQ_W'(w_dr);
            r_sq_g <= SQ_W'(w_dg) * SQ_W'(w_dg);
            r_sq_b <= SQ_W'(w_db) * SQ_W'(w_db);
            r_ent2 <= i_ent;
            r_act2 <= i_act;
        end
    end

    // stage 3: distance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
            r_ent3 <= r_ent2;
            r_act3 <= r_act2;
        end
    end

    assign o_dist = r_dist;
    assign o_ent  = r_ent3;
    assign o_act  = r_act3;

endmodule

`default_nettype wire

// ===== hdl/nppm_min_tree.sv =====
`default_nettype none

// registered minimum tree, lower index wins on equal distance
module nppm_min_tree #(
    parameter int DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [nppm_pkg::DIST_W-1:0] i_dist [DEPTH],
    input  wire nppm_pkg::t_rgb i_ent [DEPTH],
    input  wire logic       i_act  [DEPTH],
    output logic            o_found,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_idx,
    output nppm_pkg::t_rgb  o_rgb
);
    import nppm_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVLS  = $clog2(DEPTH);
    localparam int LEAFS = 1 << LVLS;
    localparam int NODES = 2 * LEAFS - 1;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
        t_rgb              rgb;
    } t_cand;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand res;
        res = (b.vld && (!a.vld || (b.sq_dist < a.sq_dist))) ? b : a;
        return res;
    endfunction

    t_cand w_node [NODES];

    // leaves, padding leaves never win
    for (genvar j = 0; j < LEAFS; j++) begin : g_leaf
        if (j < DEPTH) begin : g_real
            assign w_node[LEAFS-1+j] = '{vld: i_act[j], sq_dist: i_dist[j],
                                         idx: IDX_W'(j), rgb: i_ent[j]};
        end else begin : g_pad
            assign w_node[LEAFS-1+j] = '0;
        end
    end

    // one register level per tree level
    if (LVLS > 0) begin : g_tree
        t_cand r_node [LEAFS-1];
        for (genvar k = 0; k < LEAFS - 1; k++) begin : g_node
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_node[k] <= pick(w_node[2*k+1], w_node[2*k+2]);
                end
            end
            assign w_node[k] = r_node[k];
        end
    end

    assign o_found = w_node[0].vld;
    assign o_idx   = w_node[0].idx;
    assign o_rgb   = w_node[0].rgb;

endmodule

`default_nettype wire
